/* rtl/core/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the filter RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/rtpl_pkg.sv */
// ============================================================================
// Resonant lowpass package
// Shared widths, coefficient limits, control types and helpers.
// ============================================================================
`default_nettype none

package rtpl_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS       = 16;
    localparam int STATE_BITS      = 32;
    localparam int WIDE_BITS       = 36;
    localparam int MUL_B_BITS      = COEF_BITS + 1;
    localparam int PROD_BITS       = WIDE_BITS + MUL_B_BITS;
    localparam int SUM_BITS        = 38;
    localparam int RES_FRAC        = 14;
    localparam int CUT_FRAC        = 16;

    localparam logic [COEF_BITS-1:0] CUT_MAX = 16'd62259;
    localparam logic [COEF_BITS-1:0] RES_MAX = 16'd65208;

    typedef enum logic [1:0] {
        SRC_FEEDBACK  = 2'd0,
        SRC_STAGE_ONE = 2'd1,
        SRC_STAGE_TWO = 2'd2
    } t_mul_src;

    typedef struct packed {
        logic     ready;
        logic     load;
        logic     mul_en;
        t_mul_src src;
        logic     upd_one;
        logic     upd_two;
    } t_ctrl;

    function automatic logic [COEF_BITS-1:0] clamp_coef(
        input logic [COEF_BITS-1:0] value,
        input logic [COEF_BITS-1:0] limit
    );
        return (value > limit) ? limit : value;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_BITS-1:0] value
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'(64'sd2147483647);
        lo = SUM_BITS'(-64'sd2147483648);
        if (value > hi) begin
            return STATE_BITS'(hi);
        end else if (value < lo) begin
            return STATE_BITS'(lo);
        end
        return STATE_BITS'(value);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/resonant_two_pole_lowpass.sv */
// ============================================================================
// Resonant two-pole lowpass
// Two cascaded one-pole stages with resonance feedback from the second stage.
// ============================================================================
// An accepted word passes through the feedback product, the first stage
// product and update, and the second stage product and update before it
// reaches the result register. The three products depend on one another. They
// pass in turn through the one shared multiplier, and each product is followed
// by a register. A new word is accepted only after the previous word's second
// stage update. The second stage update waits while the previous result is
// still held in the output register. The input is accepted again while a
// finished result still waits in the output register. The resonance register
// may be written at any time the filter is idle.
`default_nettype none

module resonant_two_pole_lowpass #(
    parameter int SAMPLE_BITS = rtpl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rtpl_pkg::COEF_BITS-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  wire logic [rtpl_pkg::COEF_BITS-1:0] i_cutoff,
    input  wire logic                           i_start_req,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out
);
    import rtpl_pkg::*;

    `include "assert_macros.svh"

    localparam longint OUT_MAX_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [STATE_BITS-1:0] OUT_MAX = STATE_BITS'(OUT_MAX_L);
    localparam logic signed [STATE_BITS-1:0] OUT_MIN = STATE_BITS'(-OUT_MAX_L - 64'sd1);

    logic [COEF_BITS-1:0]          r_res;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [COEF_BITS-1:0]          r_ct;
    logic signed [STATE_BITS-1:0]  r_s1;
    logic signed [STATE_BITS-1:0]  r_s2;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic signed [STATE_BITS-1:0]  n_s1;
    logic signed [STATE_BITS-1:0]  n_s2;
    logic signed [SAMPLE_BITS-1:0] n_out;

    t_ctrl                         w_ctrl;
    logic                          w_out_free;
    logic [COEF_BITS-1:0]          w_res_c;
    logic signed [WIDE_BITS-1:0]   w_fb;
    logic signed [WIDE_BITS-1:0]   w_mul_a;
    logic signed [MUL_B_BITS-1:0]  w_mul_b;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [SUM_BITS-1:0]    w_step;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_ctrl.ready;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out;

    rtpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    always_comb begin
        w_res_c = clamp_coef(r_res, RES_MAX);
        w_fb    = WIDE_BITS'(w_prod >>> RES_FRAC);
        case (w_ctrl.src)
            SRC_FEEDBACK: begin
                w_mul_a = WIDE_BITS'(r_s2);
                w_mul_b = MUL_B_BITS'({1'b0, w_res_c});
            end
            SRC_STAGE_ONE: begin
                w_mul_a = WIDE_BITS'(r_x) - w_fb - WIDE_BITS'(r_s1);
                w_mul_b = MUL_B_BITS'({1'b0, r_ct});
            end
            SRC_STAGE_TWO: begin
                w_mul_a = WIDE_BITS'(r_s1) - WIDE_BITS'(r_s2);
                w_mul_b = MUL_B_BITS'({1'b0, r_ct});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    rtpl_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        w_step = SUM_BITS'(w_prod >>> CUT_FRAC);
        n_s1   = sat_state(SUM_BITS'(r_s1) + w_step);
        n_s2   = sat_state(SUM_BITS'(r_s2) + w_step);
        if (n_s2 > OUT_MAX) begin
            n_out = SAMPLE_BITS'(OUT_MAX);
        end else if (n_s2 < OUT_MIN) begin
            n_out = SAMPLE_BITS'(OUT_MIN);
        end else begin
            n_out = n_s2[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res       <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_res <= i_cfg_data;
            end
            if (w_ctrl.load && i_start_req) begin
                r_s1 <= '0;
                r_s2 <= '0;
            end
            if (w_ctrl.upd_one) begin
                r_s1 <= n_s1;
            end
            if (w_ctrl.upd_two) begin
                r_s2        <= n_s2;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_x  <= i_sample_in;
            r_ct <= clamp_coef(i_cutoff, CUT_MAX);
        end
        if (w_ctrl.upd_two) begin
            r_out <= n_out;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMPLIES(a_idle_no_work, i_clk, i_rst_n, o_in_ready, !w_ctrl.mul_en && !w_ctrl.upd_two)
    `ASSERT_IMPLIES(a_result_from_update, i_clk, i_rst_n, $rose(o_out_valid), $past(w_ctrl.upd_two))

endmodule

`default_nettype wire

/* rtl/core/rtpl_mul.sv */
// ============================================================================
// Shared multiplier
// Signed wide-by-coefficient multiplier with a registered product.
// ============================================================================
`default_nettype none

module rtpl_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [rtpl_pkg::WIDE_BITS-1:0] i_a,
    input  wire logic signed [rtpl_pkg::MUL_B_BITS-1:0] i_b,
    output logic signed [rtpl_pkg::PROD_BITS-1:0]      o_prod
);
    import rtpl_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [PROD_BITS-1:0] n_prod;

    always_comb begin
        n_prod = PROD_BITS'(i_a) * PROD_BITS'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/core/rtpl_ctrl.sv */
// ============================================================================
// Filter sequencer
// Steps one sample through three multiplier passes and two stage updates.
// ============================================================================
`default_nettype none

module rtpl_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_free,
    output rtpl_pkg::t_ctrl o_ctrl
);
    import rtpl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FB   = 6'b000010,
        S_ST1  = 6'b000100,
        S_UP1  = 6'b001000,
        S_ST2  = 6'b010000,
        S_UP2  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_ctrl  w_ctrl;

    always_comb begin
        n_state        = r_state;
        w_ctrl.ready   = 1'b0;
        w_ctrl.load    = 1'b0;
        w_ctrl.mul_en  = 1'b0;
        w_ctrl.src     = SRC_FEEDBACK;
        w_ctrl.upd_one = 1'b0;
        w_ctrl.upd_two = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_ctrl.ready = 1'b1;
                if (i_in_valid) begin
                    w_ctrl.load = 1'b1;
                    n_state     = S_FB;
                end
            end
            S_FB: begin
                w_ctrl.mul_en = 1'b1;
                w_ctrl.src    = SRC_FEEDBACK;
                n_state       = S_ST1;
            end
            S_ST1: begin
                w_ctrl.mul_en = 1'b1;
                w_ctrl.src    = SRC_STAGE_ONE;
                n_state       = S_UP1;
            end
            S_UP1: begin
                w_ctrl.upd_one = 1'b1;
                n_state        = S_ST2;
            end
            S_ST2: begin
                w_ctrl.mul_en = 1'b1;
                w_ctrl.src    = SRC_STAGE_TWO;
                n_state       = S_UP2;
            end
            S_UP2: begin
                if (i_out_free) begin
                    w_ctrl.upd_two = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

`default_nettype wire

/* tb/resonant_two_pole_lowpass_checker.sv */
// ----------------------------------------------------------------------------
// Resonant lowpass checker
// Watches the configuration, input and output channels of the filter. It keeps
// its own copy of the resonance register and both stage values, predicts the
// filtered sample for every accepted input word and compares it with the
// oldest prediction when an output word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module resonant_two_pole_lowpass_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [rtpl_pkg::COEF_BITS-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  wire logic [rtpl_pkg::COEF_BITS-1:0] i_cutoff,
    input  wire logic                           i_start_req,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_out,
    output int                                  o_errors,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [rtpl_pkg::COEF_BITS-1:0] res_reg;
    longint                         lp_one;
    longint                         lp_two;
    logic signed [SAMPLE_BITS-1:0]  filtered_q[$];

    function automatic longint clip_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] filter_step(
        logic signed [SAMPLE_BITS-1:0]  x_in,
        logic [rtpl_pkg::COEF_BITS-1:0] cut_in,
        logic                           clear
    );
        longint x;
        longint ct;
        longint rs;
        longint drive;
        longint s1;
        longint s2;
        x  = x_in;
        ct = (cut_in > rtpl_pkg::CUT_MAX) ? rtpl_pkg::CUT_MAX : cut_in;
        rs = (res_reg > rtpl_pkg::RES_MAX) ? rtpl_pkg::RES_MAX : res_reg;
        if (clear) begin
            lp_one = 0;
            lp_two = 0;
        end
        drive  = x - ((rs * lp_two) >>> rtpl_pkg::RES_FRAC);
        s1     = clip_to(lp_one + ((ct * (drive - lp_one)) >>> rtpl_pkg::CUT_FRAC), 32);
        s2     = clip_to(lp_two + ((ct * (s1 - lp_two)) >>> rtpl_pkg::CUT_FRAC), 32);
        lp_one = s1;
        lp_two = s2;
        return SAMPLE_BITS'(clip_to(s2, SAMPLE_BITS));
    endfunction

    always @(posedge i_clk) begin
        logic signed [SAMPLE_BITS-1:0] want;
        if (!i_rst_n) begin
            res_reg = '0;
            lp_one  = 0;
            lp_two  = 0;
            filtered_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                res_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                filtered_q.push_back(filter_step(i_sample_in, i_cutoff, i_start_req));
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected output word, expected none, actual %0d",
                             $time, i_sample_out);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_sample_out !== want) begin
                        o_errors++;
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, want, i_sample_out);
                    end
                end
            end
        end
        o_pending = filtered_q.size();
    end

endmodule

`default_nettype wire

/* tb/resonant_two_pole_lowpass_test.sv */
// ----------------------------------------------------------------------------
// Resonant lowpass testbench
// Drives the filter with a short directed set of extreme samples, cutoffs and
// resonance settings, then with random runs of words under several resonance
// values, with bursty input, a stalling receiver and long output hold-offs.
// The checker module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module resonant_two_pole_lowpass_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 24;
    localparam int SETTLE   = 12;
    localparam int HOLD_LEN = 300;
    localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rtpl_pkg::COEF_BITS-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic signed [SAMPLE_W-1:0]     i_sample_in;
    logic [rtpl_pkg::COEF_BITS-1:0] i_cutoff;
    logic                           i_start_req;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic signed [SAMPLE_W-1:0]     o_sample_out;

    int errors;
    int pending;
    int burst_left;
    bit dense_tx;
    bit rx_free;
    bit hold_req;
    int hold_left;
    int rx_run;
    bit rx_on;

    resonant_two_pole_lowpass #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_cutoff     (i_cutoff),
        .i_start_req  (i_start_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    resonant_two_pole_lowpass_checker #(
        .SAMPLE_BITS(SAMPLE_W)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_cutoff     (i_cutoff),
        .i_start_req  (i_start_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("resonant_two_pole_lowpass_test: done, errors");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_LEN - 1;
            i_out_ready <= 1'b0;
        end else if (rx_free) begin
            i_out_ready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_on  = !rx_on;
                rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            rx_run      = rx_run - 1;
            i_out_ready <= rx_on;
        end
    end

    task automatic write_resonance(logic [rtpl_pkg::COEF_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                break;
            end
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_word(
        logic signed [SAMPLE_W-1:0]     x,
        logic [rtpl_pkg::COEF_BITS-1:0] ct,
        logic                           st
    );
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        i_cutoff    <= ct;
        i_start_req <= st;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) begin
                break;
            end
        end
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = dense_tx ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic play_run(int n, bit noisy);
        int                             smode;
        int                             cmode;
        logic signed [SAMPLE_W-1:0]     x;
        logic signed [SAMPLE_W-1:0]     held;
        logic [rtpl_pkg::COEF_BITS-1:0] ct;
        logic [rtpl_pkg::COEF_BITS-1:0] ct_run;
        logic                           st;
        smode  = $urandom_range(0, 3);
        cmode  = $urandom_range(0, 4);
        held   = SAMPLE_W'($urandom);
        ct_run = 16'($urandom);
        if (cmode == 1) begin
            ct_run = 16'hFFFF;
        end else if (cmode == 2) begin
            ct_run = 16'($urandom_range(0, 64));
        end else if (cmode == 3) begin
            ct_run = 16'($urandom_range(62250, 62270));
        end
        for (int i = 0; i < n; i++) begin
            case (smode)
                0: x = SAMPLE_W'($urandom);
                1: x = $urandom_range(0, 1) ? SMAX : SMIN;
                2: x = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        held = SAMPLE_W'($urandom);
                    end
                    x = held;
                end
            endcase
            ct = (cmode == 4) ? 16'($urandom) : ct_run;
            st = noisy ? ($urandom_range(0, 7) == 0) : (i == 0);
            send_word(x, ct, st);
            pace_sender();
        end
    endtask

    initial begin
        logic [rtpl_pkg::COEF_BITS-1:0] res_list[8];
        int                             left;
        int                             n;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_cutoff    = '0;
        i_start_req = 1'b0;
        i_out_ready = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        rx_run      = 0;
        rx_on       = 1'b0;
        rx_free     = 1'b1;
        dense_tx    = 1'b1;
        burst_left  = 1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(SMAX, 16'hFFFF, 1'b1);
        send_word(SMAX, 16'hFFFF, 1'b0);
        send_word(SMAX, rtpl_pkg::CUT_MAX, 1'b0);
        send_word(SMAX, rtpl_pkg::CUT_MAX + 16'd1, 1'b0);
        send_word(SMIN, 16'h0000, 1'b0);
        send_word(SMIN, 16'hFFFF, 1'b1);
        send_word(SMIN, 16'hFFFF, 1'b0);
        send_word('0, 16'h8000, 1'b0);
        send_word(-24'sd1, 16'h0001, 1'b0);
        drain();
        write_resonance(16'hFFFF);
        send_word(SMAX, 16'hFFFF, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_word((i % 2 == 0) ? SMIN : SMAX, 16'hFFFF, 1'b0);
        end
        drain();
        write_resonance(rtpl_pkg::RES_MAX);
        send_word(SMAX, rtpl_pkg::CUT_MAX, 1'b1);
        for (int i = 0; i < 4; i++) begin
            send_word((i % 2 == 0) ? SMIN : SMAX, rtpl_pkg::CUT_MAX, 1'b0);
        end
        drain();

        res_list = '{16'd0, 16'hFFFF, rtpl_pkg::RES_MAX, 16'd16384,
                     16'($urandom), rtpl_pkg::RES_MAX + 16'd1, 16'($urandom), 16'd40000};
        for (int p = 0; p < 8; p++) begin
            write_resonance(res_list[p]);
            rx_free  = (p == 0) || (p == 6);
            dense_tx = (p == 2) || (p == 6);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            left = 235;
            while (left > 0) begin
                n = $urandom_range(10, 60);
                if (n > left) begin
                    n = left;
                end
                play_run(n, $urandom_range(0, 4) == 0);
                left = left - n;
                if (p == 5 && left < 120 && left + n >= 120) begin
                    drain();
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("resonant_two_pole_lowpass_test: done, clean");
        end else begin
            $display("resonant_two_pole_lowpass_test: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
